// ----- rtl/chell_pkg.sv -----
// Shared types, codes and field widths of the COO to hacked-ELLPACK converter.
package chell_pkg;

    localparam int MAX_ROWS_DEF    = 1024;
    localparam int MAX_COLS_DEF    = 1024;
    localparam int MAX_ENTRIES_DEF = 4096;

    localparam int CMDW  = 2;
    localparam int ROWW  = 10;
    localparam int COLW  = 10;
    localparam int VALW  = 64;
    localparam int KINDW = 2;
    localparam int OFSW  = 23;
    localparam int CNTW  = 13;
    localparam int STATW = 3;
    localparam int CFGW  = 11;
    localparam int CFGIW = 1;
    // row arithmetic width, holds MAX_ROWS up to 65536
    localparam int RIW   = 17;

    localparam logic [CFGIW-1:0] REG_NUM_ROWS  = 1'b0;
    localparam logic [CFGIW-1:0] REG_HACK_SIZE = 1'b1;

    typedef enum logic [CMDW-1:0] {
        CMD_CLEAR = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_EMIT  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [KINDW-1:0] {
        KIND_ACK    = 2'd0,
        KIND_DATA   = 2'd1,
        KIND_RECORD = 2'd2,
        KIND_DONE   = 2'd3
    } kind_t;

    typedef enum logic [STATW-1:0] {
        STAT_OK        = 3'd0,
        STAT_ORDER     = 3'd1,
        STAT_RANGE     = 3'd2,
        STAT_FULL      = 3'd3,
        STAT_EMIT_LOAD = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_LDWR,
        S_SCAN,
        S_EMIT,
        S_EDRD,
        S_EDST
    } state_t;

    typedef struct packed {
        kind_t               kind;
        logic [COLW-1:0]     col;
        logic [VALW-1:0]     val;
        logic [OFSW-1:0]     ofs;
        logic [CNTW-1:0]     width;
        status_t             status;
        logic                last;
    } result_t;

endpackage

// ----- rtl/chell_ram.sv -----
// Simple dual-port synchronous RAM with a registered read.
module chell_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 13,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end
endmodule

// ----- rtl/coo_to_hacked_ellpack_converter.sv -----
// Top level of the COO to hacked-ELLPACK converter.
//
//  channel   | handshake              | payload
//  ----------+------------------------+--------------------------------------------
//  request   | start / busy           | command, row, column, value
//  result    | done (one-cycle pulse) | kind, slot_column, slot_value,
//            |                        | hack_end_offset, hack_width, status, last
//  config    | cfg_we                 | cfg_index, cfg_data
//
// From the accepting edge to the result, one request at a time: a rejected
// load or command three is answered straight from the idle state; a stored
// load reads the row count, then writes it back; an emitted data slot reads
// the row count, then, for a stored entry, the entry store; the final hack
// end record is answered from the emit state; any other hack end record first
// scans the next hack's row counts one row per cycle, then the read pipeline
// drains. The first emit also scans the first hack before its item.
// Reset and the clear command sweep the whole row count RAM with busy high;
// clear answers its acknowledge when the sweep ends.
// The receiver cannot stall: each result shows for one cycle under done.
module coo_to_hacked_ellpack_converter #(
    parameter int MAX_ROWS    = chell_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS    = chell_pkg::MAX_COLS_DEF,
    parameter int MAX_ENTRIES = chell_pkg::MAX_ENTRIES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [chell_pkg::CMDW-1:0]    command,
    input  logic [chell_pkg::ROWW-1:0]    row,
    input  logic [chell_pkg::COLW-1:0]    column,
    input  logic [chell_pkg::VALW-1:0]    value,
    input  logic                          cfg_we,
    input  logic [chell_pkg::CFGIW-1:0]   cfg_index,
    input  logic [chell_pkg::CFGW-1:0]    cfg_data,
    output logic                          done,
    output logic [chell_pkg::KINDW-1:0]   kind,
    output logic [chell_pkg::COLW-1:0]    slot_column,
    output logic [chell_pkg::VALW-1:0]    slot_value,
    output logic [chell_pkg::OFSW-1:0]    hack_end_offset,
    output logic [chell_pkg::CNTW-1:0]    hack_width,
    output logic [chell_pkg::STATW-1:0]   status,
    output logic                          last
);
    import chell_pkg::*;

    localparam int RAW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int EAW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int EW  = $clog2(MAX_ENTRIES + 1);
    localparam int SW  = COLW + VALW;

    // configuration
    logic [CFGW-1:0] num_rows_reg, hack_size_reg;

    // control state
    state_t          state_reg, state_next;
    logic [EW-1:0]   entry_count_reg, entry_count_next;
    logic [ROWW-1:0] prev_row_reg, prev_row_next;
    logic            emitting_reg, emitting_next;
    logic            finished_reg, finished_next;
    logic [RIW-1:0]  hack_first_reg, hack_first_next;
    logic [RIW-1:0]  row_in_hack_reg, row_in_hack_next;
    logic [CNTW-1:0] slot_reg, slot_next;
    logic [EW-1:0]   rp_reg, rp_next;
    logic [CNTW-1:0] hmax_reg, hmax_next;
    logic [OFSW-1:0] offset_reg, offset_next;
    logic [COLW-1:0] last_col_reg, last_col_next;
    logic [RAW-1:0]  clr_addr_reg, clr_addr_next;
    logic            ack_pend_reg, ack_pend_next;
    logic [RIW-1:0]  scan_idx_reg, scan_idx_next;
    logic            scan_vld_reg, scan_vld_next;
    logic            scan_emit_reg, scan_emit_next;
    logic            done_reg, done_next;

    // payload state
    logic [RAW-1:0]  ld_row_reg, ld_row_next;
    result_t         out_reg, out_next;

    // memories
    logic            cnt_we;
    logic [RAW-1:0]  cnt_waddr, cnt_raddr;
    logic [CNTW-1:0] cnt_wdata, cnt_rdata;
    logic            ent_we;
    logic [EAW-1:0]  ent_waddr, ent_raddr;
    logic [SW-1:0]   ent_wdata, ent_rdata;

    // derived sizes
    logic [RIW-1:0]  rows, hsz, left, hlen, cur_row, scan_row, row_ext, col_ext;
    logic [CNTW-1:0] slot_inc;

    // slot emission, shared by two states
    logic            emit_slot;
    logic [COLW-1:0] emit_col;
    logic [VALW-1:0] emit_val;

    chell_ram #(.DEPTH(MAX_ROWS), .WIDTH(CNTW), .AW(RAW)) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    chell_ram #(.DEPTH(MAX_ENTRIES), .WIDTH(SW), .AW(EAW)) u_ent_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    // Clamp the registers anew on every use.
    always_comb
    begin
        if (num_rows_reg == '0)
            rows = RIW'(1);
        else if (RIW'(num_rows_reg) > RIW'(MAX_ROWS))
            rows = RIW'(MAX_ROWS);
        else
            rows = RIW'(num_rows_reg);

        if (hack_size_reg == '0)
            hsz = RIW'(1);
        else if (RIW'(hack_size_reg) > rows)
            hsz = rows;
        else
            hsz = RIW'(hack_size_reg);

        left     = (hack_first_reg < rows) ? rows - hack_first_reg : '0;
        hlen     = (left < hsz) ? left : hsz;
        cur_row  = hack_first_reg + row_in_hack_reg;
        scan_row = hack_first_reg + scan_idx_reg;
        row_ext  = RIW'(row);
        col_ext  = RIW'(column);
        slot_inc = slot_reg + CNTW'(1);
    end

    always_comb
    begin
        state_next       = state_reg;
        entry_count_next = entry_count_reg;
        prev_row_next    = prev_row_reg;
        emitting_next    = emitting_reg;
        finished_next    = finished_reg;
        hack_first_next  = hack_first_reg;
        row_in_hack_next = row_in_hack_reg;
        slot_next        = slot_reg;
        rp_next          = rp_reg;
        hmax_next        = hmax_reg;
        offset_next      = offset_reg;
        last_col_next    = last_col_reg;
        clr_addr_next    = clr_addr_reg;
        ack_pend_next    = ack_pend_reg;
        scan_idx_next    = scan_idx_reg;
        scan_vld_next    = scan_vld_reg;
        scan_emit_next   = scan_emit_reg;
        done_next        = 1'b0;
        ld_row_next      = ld_row_reg;
        out_next         = out_reg;

        cnt_we    = 1'b0;
        cnt_waddr = clr_addr_reg;
        cnt_wdata = '0;
        cnt_raddr = row_ext[RAW-1:0];
        ent_we    = 1'b0;
        ent_waddr = entry_count_reg[EAW-1:0];
        ent_wdata = {column, value};
        ent_raddr = rp_reg[EAW-1:0];

        emit_slot = 1'b0;
        emit_col  = '0;
        emit_val  = '0;

        unique case (state_reg)
            S_CLR:
            begin
                // zero one row count per cycle
                cnt_we        = 1'b1;
                cnt_waddr     = clr_addr_reg;
                clr_addr_next = clr_addr_reg + RAW'(1);
                if (clr_addr_reg == RAW'(MAX_ROWS - 1))
                begin
                    clr_addr_next = '0;
                    state_next    = S_IDLE;
                    done_next     = ack_pend_reg;
                    ack_pend_next = 1'b0;
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    out_next = '{kind: KIND_ACK, col: '0, val: '0, ofs: '0,
                                 width: '0, status: STAT_OK, last: 1'b0};
                    unique case (cmd_t'(command))
                        CMD_CLEAR:
                        begin
                            entry_count_next = '0;
                            prev_row_next    = '0;
                            emitting_next    = 1'b0;
                            finished_next    = 1'b0;
                            hack_first_next  = '0;
                            row_in_hack_next = '0;
                            slot_next        = '0;
                            rp_next          = '0;
                            hmax_next        = '0;
                            offset_next      = '0;
                            last_col_next    = '0;
                            clr_addr_next    = '0;
                            ack_pend_next    = 1'b1;
                            state_next       = S_CLR;
                        end
                        CMD_LOAD:
                        begin
                            if (emitting_reg)
                            begin
                                out_next.status = STAT_EMIT_LOAD;
                                done_next       = 1'b1;
                            end
                            else if (row_ext >= rows || col_ext >= RIW'(MAX_COLS))
                            begin
                                out_next.status = STAT_RANGE;
                                done_next       = 1'b1;
                            end
                            else if (entry_count_reg != '0 && row < prev_row_reg)
                            begin
                                out_next.status = STAT_ORDER;
                                done_next       = 1'b1;
                            end
                            else if (entry_count_reg >= EW'(MAX_ENTRIES))
                            begin
                                out_next.status = STAT_FULL;
                                done_next       = 1'b1;
                            end
                            else
                            begin
                                // store the entry, fetch the row count
                                ent_we           = 1'b1;
                                entry_count_next = entry_count_reg + EW'(1);
                                prev_row_next    = row;
                                ld_row_next      = row_ext[RAW-1:0];
                                state_next       = S_LDWR;
                            end
                        end
                        CMD_EMIT:
                        begin
                            if (!emitting_reg)
                            begin
                                emitting_next    = 1'b1;
                                hack_first_next  = '0;
                                row_in_hack_next = '0;
                                slot_next        = '0;
                                rp_next          = '0;
                                offset_next      = '0;
                                last_col_next    = '0;
                                hmax_next        = '0;
                                scan_idx_next    = '0;
                                scan_vld_next    = 1'b0;
                                scan_emit_next   = 1'b1;
                                state_next       = S_SCAN;
                            end
                            else
                            begin
                                state_next = S_EMIT;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            S_LDWR:
            begin
                cnt_we     = 1'b1;
                cnt_waddr  = ld_row_reg;
                cnt_wdata  = cnt_rdata + CNTW'(1);
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            S_SCAN:
            begin
                // one row count read per cycle, compared in the next cycle
                cnt_raddr = scan_row[RAW-1:0];
                if (scan_idx_reg < hlen)
                begin
                    scan_idx_next = scan_idx_reg + RIW'(1);
                    scan_vld_next = 1'b1;
                end
                else
                begin
                    scan_vld_next = 1'b0;
                end
                if (scan_vld_reg && cnt_rdata > hmax_reg)
                    hmax_next = cnt_rdata;
                if (scan_idx_reg >= hlen && !scan_vld_reg)
                begin
                    if (scan_emit_reg)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end

            S_EMIT:
            begin
                if (finished_reg || hack_first_reg >= rows)
                begin
                    finished_next = 1'b1;
                    out_next = '{kind: KIND_DONE, col: '0, val: '0, ofs: '0,
                                 width: '0, status: STAT_OK, last: 1'b0};
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (row_in_hack_reg >= hlen || hmax_reg == '0)
                begin
                    out_next = '{kind: KIND_RECORD, col: '0, val: '0, ofs: offset_reg,
                                 width: hmax_reg, status: STAT_OK,
                                 last: (hack_first_reg + hlen >= rows)};
                    hack_first_next  = hack_first_reg + hlen;
                    row_in_hack_next = '0;
                    slot_next        = '0;
                    if (hack_first_reg + hlen >= rows)
                    begin
                        finished_next = 1'b1;
                        done_next     = 1'b1;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        // hold the record until the next hack's maximum is known
                        hmax_next      = '0;
                        scan_idx_next  = '0;
                        scan_vld_next  = 1'b0;
                        scan_emit_next = 1'b0;
                        state_next     = S_SCAN;
                    end
                end
                else
                begin
                    cnt_raddr  = cur_row[RAW-1:0];
                    state_next = S_EDRD;
                end
            end

            S_EDRD:
            begin
                if (cnt_rdata == '0)
                begin
                    emit_slot = 1'b1;
                end
                else if (slot_reg < cnt_rdata && rp_reg < entry_count_reg)
                begin
                    ent_raddr  = rp_reg[EAW-1:0];
                    rp_next    = rp_reg + EW'(1);
                    state_next = S_EDST;
                end
                else
                begin
                    emit_slot = 1'b1;
                    emit_col  = last_col_reg;
                end
            end

            S_EDST:
            begin
                emit_slot     = 1'b1;
                emit_col      = ent_rdata[SW-1:VALW];
                emit_val      = ent_rdata[VALW-1:0];
                last_col_next = ent_rdata[SW-1:VALW];
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (emit_slot)
        begin
            out_next = '{kind: KIND_DATA, col: emit_col, val: emit_val, ofs: '0,
                         width: '0, status: STAT_OK, last: 1'b0};
            offset_next = offset_reg + OFSW'(1);
            done_next   = 1'b1;
            state_next  = S_IDLE;
            if (slot_inc >= hmax_reg)
            begin
                slot_next        = '0;
                row_in_hack_next = row_in_hack_reg + RIW'(1);
            end
            else
            begin
                slot_next = slot_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg  <= CFGW'(1);
            hack_size_reg <= CFGW'(32);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_NUM_ROWS:  num_rows_reg  <= cfg_data;
                REG_HACK_SIZE: hack_size_reg <= cfg_data;
                default:       num_rows_reg  <= num_rows_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLR;
            entry_count_reg <= '0;
            prev_row_reg    <= '0;
            emitting_reg    <= 1'b0;
            finished_reg    <= 1'b0;
            hack_first_reg  <= '0;
            row_in_hack_reg <= '0;
            slot_reg        <= '0;
            rp_reg          <= '0;
            hmax_reg        <= '0;
            offset_reg      <= '0;
            last_col_reg    <= '0;
            clr_addr_reg    <= '0;
            ack_pend_reg    <= 1'b0;
            scan_idx_reg    <= '0;
            scan_vld_reg    <= 1'b0;
            scan_emit_reg   <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            entry_count_reg <= entry_count_next;
            prev_row_reg    <= prev_row_next;
            emitting_reg    <= emitting_next;
            finished_reg    <= finished_next;
            hack_first_reg  <= hack_first_next;
            row_in_hack_reg <= row_in_hack_next;
            slot_reg        <= slot_next;
            rp_reg          <= rp_next;
            hmax_reg        <= hmax_next;
            offset_reg      <= offset_next;
            last_col_reg    <= last_col_next;
            clr_addr_reg    <= clr_addr_next;
            ack_pend_reg    <= ack_pend_next;
            scan_idx_reg    <= scan_idx_next;
            scan_vld_reg    <= scan_vld_next;
            scan_emit_reg   <= scan_emit_next;
            done_reg        <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ld_row_reg <= ld_row_next;
        out_reg    <= out_next;
    end

    assign busy            = (state_reg != S_IDLE);
    assign done            = done_reg;
    assign kind            = out_reg.kind;
    assign slot_column     = out_reg.col;
    assign slot_value      = out_reg.val;
    assign hack_end_offset = out_reg.ofs;
    assign hack_width      = out_reg.width;
    assign status          = out_reg.status;
    assign last            = out_reg.last;
endmodule

// ----- rtl/chell_chk.sv -----
// Port-level checker for the converter, bound to the top level.
module chell_chk (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          done,
    input logic [chell_pkg::KINDW-1:0]   kind,
    input logic [chell_pkg::COLW-1:0]    slot_column,
    input logic [chell_pkg::VALW-1:0]    slot_value,
    input logic [chell_pkg::STATW-1:0]   status,
    input logic                          last
);
    import chell_pkg::*;

    // an accepted request either keeps the block busy or answers at once
    a_accept_answer: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || done)
        else $error("request neither answered nor in progress");

    a_status_ack: assert property (@(posedge clk) disable iff (!rst_n)
        done && kind != KIND_ACK |-> status == STAT_OK)
        else $error("nonzero status outside an acknowledge");

    a_last_record: assert property (@(posedge clk) disable iff (!rst_n)
        done && last |-> kind == KIND_RECORD)
        else $error("last flag outside a hack end record");

    a_slot_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done && kind != KIND_DATA |-> slot_value == '0 && slot_column == '0)
        else $error("slot payload outside a data slot");
endmodule

bind coo_to_hacked_ellpack_converter chell_chk u_chell_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .kind        (kind),
    .slot_column (slot_column),
    .slot_value  (slot_value),
    .status      (status),
    .last        (last)
);

// ----- test/tb_top.sv -----
// Self-checking testbench for the COO to hacked-ELLPACK converter.
module tb_top;
    import chell_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NROWS = MAX_ROWS_DEF;
    localparam int NCOLS = MAX_COLS_DEF;
    localparam int NENT  = MAX_ENTRIES_DEF;

    // One request as queued for the driver. A pause entry holds the driver off
    // until every expected result has arrived; a config entry writes a register.
    typedef struct {
        bit                 is_pause;
        bit                 is_cfg;
        logic [CFGIW-1:0]   cfg_idx;
        logic [CFGW-1:0]    cfg_val;
        cmd_t               cmd;
        logic [ROWW-1:0]    r;
        logic [COLW-1:0]    c;
        logic [VALW-1:0]    v;
    } request_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [CMDW-1:0]    command;
    logic [ROWW-1:0]    row;
    logic [COLW-1:0]    column;
    logic [VALW-1:0]    value;
    logic               cfg_we;
    logic [CFGIW-1:0]   cfg_index;
    logic [CFGW-1:0]    cfg_data;
    logic               done;
    logic [KINDW-1:0]   kind;
    logic [COLW-1:0]    slot_column;
    logic [VALW-1:0]    slot_value;
    logic [OFSW-1:0]    hack_end_offset;
    logic [CNTW-1:0]    hack_width;
    logic [STATW-1:0]   status;
    logic               last;

    coo_to_hacked_ellpack_converter dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .command(command), .row(row), .column(column), .value(value),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .kind(kind), .slot_column(slot_column), .slot_value(slot_value),
        .hack_end_offset(hack_end_offset), .hack_width(hack_width),
        .status(status), .last(last)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Converter shadow: own copy of the registers and of the store state.
    // ------------------------------------------------------------------
    int unsigned          sh_num_rows;
    int unsigned          sh_hack_size;
    int unsigned          cnt_per_row [NROWS];
    logic [COLW-1:0]      ent_col [NENT];
    logic [VALW-1:0]      ent_val [NENT];
    int unsigned          n_entries;
    int unsigned          prev_row;
    bit                   in_emit;
    int unsigned          hack_base;
    int unsigned          hack_row;
    int unsigned          row_slot;
    int unsigned          rd_ptr;
    int unsigned          hack_max;
    int unsigned          slot_ofs;
    logic [COLW-1:0]      last_col;
    bit                   conv_done;

    result_t              pending_results [$];
    request_t             request_q [$];

    function automatic int unsigned rows_eff();
        if (sh_num_rows == 0) return 1;
        if (sh_num_rows > NROWS) return NROWS;
        return sh_num_rows;
    endfunction

    function automatic int unsigned hack_len(int unsigned rows);
        int unsigned h;
        int unsigned left;
        h = (sh_hack_size == 0) ? 1 : ((sh_hack_size > rows) ? rows : sh_hack_size);
        left = rows - hack_base;
        return (left < h) ? left : h;
    endfunction

    function automatic int unsigned widest_row(int unsigned first, int unsigned len);
        int unsigned m;
        m = 0;
        for (int unsigned i = 0; i < len; i++)
            if (first + i < NROWS && cnt_per_row[first + i] > m) m = cnt_per_row[first + i];
        return m;
    endfunction

    function automatic void wipe_store();
        for (int i = 0; i < NROWS; i++) cnt_per_row[i] = 0;
        n_entries = 0; prev_row = 0; in_emit = 0; hack_base = 0; hack_row = 0;
        row_slot = 0; rd_ptr = 0; hack_max = 0; slot_ofs = 0; last_col = '0;
        conv_done = 0;
    endfunction

    function automatic status_t try_load(int unsigned r, int unsigned c, logic [VALW-1:0] v);
        if (in_emit) return STAT_EMIT_LOAD;
        if (r >= rows_eff() || c >= NCOLS) return STAT_RANGE;
        if (n_entries > 0 && r < prev_row) return STAT_ORDER;
        if (n_entries >= NENT) return STAT_FULL;
        ent_col[n_entries] = COLW'(c);
        ent_val[n_entries] = v;
        n_entries++;
        cnt_per_row[r]++;
        prev_row = r;
        return STAT_OK;
    endfunction

    function automatic result_t next_hll_item();
        result_t res;
        int unsigned rows;
        int unsigned len;
        int unsigned r;
        int unsigned n;
        bit is_last;
        res = '{kind: KIND_DATA, status: STAT_OK, default: '0};
        rows = rows_eff();
        if (!in_emit) begin
            in_emit = 1; hack_base = 0; hack_row = 0; row_slot = 0; rd_ptr = 0;
            slot_ofs = 0; last_col = '0;
            hack_max = widest_row(0, hack_len(rows));
        end
        if (conv_done || hack_base >= rows) begin
            conv_done = 1;
            res.kind = KIND_DONE;
            return res;
        end
        len = hack_len(rows);
        if (hack_row >= len || hack_max == 0) begin
            is_last = (hack_base + len >= rows);
            res.kind = KIND_RECORD;
            res.ofs = slot_ofs[OFSW-1:0];
            res.width = hack_max[CNTW-1:0];
            res.last = is_last;
            hack_base += len; hack_row = 0; row_slot = 0;
            if (is_last) conv_done = 1;
            else hack_max = widest_row(hack_base, hack_len(rows));
            return res;
        end
        r = hack_base + hack_row;
        n = (r < NROWS) ? cnt_per_row[r] : 0;
        if (n == 0) begin
            res.col = '0;
        end else if (row_slot < n && rd_ptr < n_entries && rd_ptr < NENT) begin
            res.col = ent_col[rd_ptr];
            res.val = ent_val[rd_ptr];
            rd_ptr++;
            last_col = res.col;
        end else begin
            res.col = last_col;
        end
        slot_ofs = (slot_ofs + 1) & 32'h7F_FFFF;
        row_slot++;
        if (row_slot >= hack_max) begin
            row_slot = 0;
            hack_row++;
        end
        return res;
    endfunction

    // Work out the expected result of one accepted request.
    function automatic void predict_request(request_t q);
        result_t res;
        res = '{kind: KIND_ACK, status: STAT_OK, default: '0};
        case (q.cmd)
            CMD_CLEAR: wipe_store();
            CMD_LOAD:  res.status = try_load(q.r, q.c, q.v);
            CMD_EMIT:  res = next_hll_item();
            default:   ;
        endcase
        pending_results.push_back(res);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    function automatic void push_cmd(cmd_t cmd, int unsigned r = 0, int unsigned c = 0,
                                     logic [VALW-1:0] v = '0);
        request_t q;
        q = '{cmd: cmd, r: ROWW'(r), c: COLW'(c), v: v, default: '0};
        request_q.push_back(q);
    endfunction

    function automatic void push_cfg(logic [CFGIW-1:0] idx, int unsigned v);
        request_t q;
        q = '{cmd: CMD_NONE, default: '0};
        q.is_pause = 1;
        request_q.push_back(q);
        q.is_pause = 0;
        q.is_cfg = 1;
        q.cfg_idx = idx;
        q.cfg_val = CFGW'(v);
        request_q.push_back(q);
    endfunction

    function automatic logic [VALW-1:0] rand_val();
        return {$urandom(), $urandom()};
    endfunction

    // One conversion: register writes, clear, loads in row order mixed with bad requests, emits, then a late load.
    // Registers are only changed across the pause that push_cfg inserts.
    function automatic void push_conversion(int unsigned nrows, int unsigned hsize,
                                            int unsigned nload);
        int unsigned r;
        int unsigned slots_bound;
        push_cfg(REG_NUM_ROWS, nrows);
        push_cfg(REG_HACK_SIZE, hsize);
        push_cmd(CMD_CLEAR);
        r = 0;
        for (int unsigned i = 0; i < nload; i++) begin
            if ($urandom_range(0, 2) == 0 && r + 1 < nrows)
                r = $urandom_range(r, (r + 3 < nrows) ? r + 3 : nrows - 1);
            case ($urandom_range(0, 15))
                0: push_cmd(CMD_LOAD, (r > 0) ? r - 1 : 0, $urandom_range(0, NCOLS - 1),
                            rand_val());
                1: push_cmd(CMD_LOAD, $urandom_range(nrows - 1 < 1023 ? nrows : 1023, 1023),
                            $urandom_range(0, NCOLS - 1), rand_val());
                2: push_cmd(CMD_NONE, $urandom_range(0, 1023), 0, rand_val());
                default: push_cmd(CMD_LOAD, r, $urandom_range(0, NCOLS - 1), rand_val());
            endcase
        end
        // Emits for slots plus records plus a few extra dones, capped at 60.
        slots_bound = nload * ((nrows < 4) ? nrows : 4) + nrows + 3;
        for (int unsigned i = 0; i < slots_bound && i < 60; i++) push_cmd(CMD_EMIT);
        // A late load is rejected once emission has begun.
        push_cmd(CMD_LOAD, 0, 0, rand_val());
    endfunction

    // ------------------------------------------------------------------
    // Driver: fed from request_q, bursts with random gaps.
    // ------------------------------------------------------------------
    int unsigned  gap_left;
    int unsigned  burst_left;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            start     <= 1'b0;
            command   <= CMD_NONE;
            row       <= '0;
            column    <= '0;
            value     <= '0;
            cfg_we    <= 1'b0;
            cfg_index <= '0;
            cfg_data  <= '0;
            gap_left  <= 0;
            burst_left <= 0;
        end else begin
            // The request driven last cycle was taken if busy was low.
            if (start && !busy) predict_request(request_q.pop_front());
            if (start && busy) begin
                // hold the pending request
                cfg_we <= 1'b0;
            end else if (request_q.size() == 0) begin
                start  <= 1'b0;
                cfg_we <= 1'b0;
            end else if (request_q[0].is_pause) begin
                start  <= 1'b0;
                cfg_we <= 1'b0;
                // release after every result is in and the block went quiet
                if (pending_results.size() == 0 && !busy && !done && !start)
                    void'(request_q.pop_front());
            end else if (request_q[0].is_cfg) begin
                start     <= 1'b0;
                cfg_we    <= 1'b1;
                cfg_index <= request_q[0].cfg_idx;
                cfg_data  <= request_q[0].cfg_val;
                if (request_q[0].cfg_idx == REG_NUM_ROWS) sh_num_rows = request_q[0].cfg_val;
                else sh_hack_size = request_q[0].cfg_val;
                void'(request_q.pop_front());
            end else if (gap_left > 0) begin
                start    <= 1'b0;
                cfg_we   <= 1'b0;
                gap_left <= gap_left - 1;
            end else begin
                start   <= 1'b1;
                cfg_we  <= 1'b0;
                command <= request_q[0].cmd;
                row     <= request_q[0].r;
                column  <= request_q[0].c;
                value   <= request_q[0].v;
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each strobed result with the oldest expectation.
    // ------------------------------------------------------------------
    int unsigned mismatches;

    always @(posedge clk) begin
        result_t want;
        if (rst_n && done) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result kind=%0d", kind);
            end else begin
                want = pending_results.pop_front();
                if (kind !== want.kind || slot_column !== want.col || slot_value !== want.val
                    || hack_end_offset !== want.ofs || hack_width !== want.width
                    || status !== want.status || last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp k%0d c%0d v%h o%0d w%0d s%0d l%0d / got k%0d c%0d v%h o%0d w%0d s%0d l%0d",
                                 want.kind, want.col, want.val, want.ofs, want.width,
                                 want.status, want.last, kind, slot_column, slot_value,
                                 hack_end_offset, hack_width, status, last);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        int unsigned nr;
        mismatches = 0;
        sh_num_rows = 1;
        sh_hack_size = 32;
        wipe_store();
        rst_n = 1'b0;
        // Directed: reset defaults, command three, range/order errors, extremes.
        push_cmd(CMD_NONE);
        push_cmd(CMD_LOAD, 1, 0, '1);          // row beyond row count
        push_cmd(CMD_LOAD, 0, 1023, '1);
        push_cmd(CMD_EMIT);
        push_cmd(CMD_EMIT);
        push_cmd(CMD_EMIT);
        push_cmd(CMD_EMIT);                    // emit after done
        push_cmd(CMD_LOAD, 0, 0, '0);          // load after emission began
        push_cfg(REG_NUM_ROWS, 1024);
        push_cfg(REG_HACK_SIZE, 2047);         // clamped to the row count
        push_cmd(CMD_CLEAR);
        push_cmd(CMD_LOAD, 1023, 1023, 64'hFFFF_FFFF_FFFF_FFFF);
        push_cmd(CMD_LOAD, 5, 3, 64'h0);       // out of order
        push_cmd(CMD_LOAD, 1023, 0, 64'h5555_AAAA_5555_AAAA);
        push_cmd(CMD_EMIT);
        push_cmd(CMD_EMIT);
        push_cmd(CMD_EMIT);
        push_cmd(CMD_EMIT);
        push_cmd(CMD_EMIT);
        // Zero registers clamp to one row and one-row hacks.
        push_conversion(0, 0, 3);
        push_conversion(3, 1, 4);
        // Random conversions, mostly small row counts.
        while (request_q.size() < 560) begin
            nr = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 1024) : $urandom_range(1, 12);
            push_conversion(nr, $urandom_range(1, ($urandom_range(0, 5) == 0) ? 2047 : 6),
                            $urandom_range(0, 10));
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        wait (request_q.size() == 0);
        wait (pending_results.size() == 0);
        repeat (NROWS + 50) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0) $display("PASSED: all results match");
        else $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #50ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/chell_pkg.sv
rtl/chell_ram.sv
rtl/coo_to_hacked_ellpack_converter.sv
rtl/chell_chk.sv
test/tb_top.sv
